// ===== design/rebd_pkg.sv =====
// ----------------------------------------------------------------------------
// rebd_pkg
// Shared widths, register indexes, result codes and gesture state codes for
// the rotary encoder and button decoder.
// ----------------------------------------------------------------------------
package rebd_pkg;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DETENT_W     = 7;
    localparam int SAMPLES_W    = 16;
    localparam int ROT_W        = 2;
    localparam int EDGE_W       = 2;
    localparam int GEST_W       = 3;
    localparam int HOLD_TICKS_W = 16;
    localparam int HOLD_SEC_W   = 15;
    localparam int SUM_W        = 8;
    localparam int STATE_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DETENT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK     = 2'd2;

    localparam logic [DETENT_W-1:0]  DETENT_RESET   = 7'd4;
    localparam logic [SAMPLES_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [SAMPLES_W-1:0] TICK_RESET     = 16'd500;

    localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
    localparam logic [ROT_W-1:0] ROT_CW   = 2'd1;
    localparam logic [ROT_W-1:0] ROT_CCW  = 2'd2;

    localparam logic [EDGE_W-1:0] EDGE_NONE    = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_PRESS   = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_RELEASE = 2'd2;

    localparam logic [GEST_W-1:0] GEST_NONE   = 3'd0;
    localparam logic [GEST_W-1:0] GEST_CLICK  = 3'd1;
    localparam logic [GEST_W-1:0] GEST_DOUBLE = 3'd2;
    localparam logic [GEST_W-1:0] GEST_TRIPLE = 3'd3;
    localparam logic [GEST_W-1:0] GEST_HOLD   = 3'd4;

    localparam logic [STATE_W-1:0] ST_START   = 4'd0;
    localparam logic [STATE_W-1:0] ST_DOWN    = 4'd1;
    localparam logic [STATE_W-1:0] ST_CLICK   = 4'd2;
    localparam logic [STATE_W-1:0] ST_DOWN2   = 4'd3;
    localparam logic [STATE_W-1:0] ST_CLICK2  = 4'd4;
    localparam logic [STATE_W-1:0] ST_DOWN3   = 4'd5;
    localparam logic [STATE_W-1:0] ST_CLICK3  = 4'd6;
    localparam logic [STATE_W-1:0] ST_HOLD    = 4'd7;
    localparam logic [STATE_W-1:0] ST_INVALID = 4'd8;

    typedef struct packed {
        logic press;
        logic release_ev;
        logic tick;
    } button_event_t;

    // old A/B in the upper bits, new A/B in the lower bits
    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] step;
        case (idx) inside
            4'd1, 4'd7, 4'd8, 4'd14:  step = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
            default:                  step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

// ===== design/rebd_ifs.sv =====
// ----------------------------------------------------------------------------
// rebd channel interfaces
// Valid/ready channels for pin samples, decoded results and register writes.
// ----------------------------------------------------------------------------
interface rebd_sample_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;
    logic button_level;

    modport source (output valid, output pin_a, output pin_b, output button_level,
                    input ready);
    modport sink   (input valid, input pin_a, input pin_b, input button_level,
                    output ready);
endinterface

interface rebd_result_if;
    import rebd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ROT_W-1:0]      rotation;
    logic [EDGE_W-1:0]     button_edge;
    logic [GEST_W-1:0]     gesture;
    logic [HOLD_SEC_W-1:0] hold_seconds;

    modport source (output valid, output rotation, output button_edge, output gesture,
                    output hold_seconds, input ready);
    modport sink   (input valid, input rotation, input button_edge, input gesture,
                    input hold_seconds, output ready);
endinterface

interface rebd_cfg_if;
    import rebd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rebd_quad.sv =====
// ----------------------------------------------------------------------------
// rebd_quad
// Quadrature step accumulator: table lookup on old/new A/B, detent compare.
// ----------------------------------------------------------------------------
module rebd_quad (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic                           pin_a,
    input  logic                           pin_b,
    input  logic [rebd_pkg::DETENT_W-1:0]  detent_steps,
    output logic [rebd_pkg::ROT_W-1:0]     rotation
);
    import rebd_pkg::*;

    logic                    prev_a_reg;
    logic                    prev_b_reg;
    logic signed [SUM_W-1:0] step_sum_reg;
    logic signed [SUM_W-1:0] step_sum_next;
    logic signed [1:0]       step;
    logic signed [SUM_W-1:0] sum_stepped;
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] neg_lim;

    always_comb
    begin
        step        = quad_step({prev_a_reg, prev_b_reg, pin_a, pin_b});
        sum_stepped = step_sum_reg + SUM_W'(step);
        lim         = SUM_W'({1'b0, detent_steps});
        neg_lim     = -lim;
        if (sum_stepped >= lim)
        begin
            rotation      = ROT_CW;
            step_sum_next = '0;
        end
        else if (sum_stepped <= neg_lim)
        begin
            rotation      = ROT_CCW;
            step_sum_next = '0;
        end
        else
        begin
            rotation      = ROT_NONE;
            step_sum_next = sum_stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg   <= 1'b1;
            prev_b_reg   <= 1'b1;
            step_sum_reg <= '0;
        end
        else if (fire)
        begin
            prev_a_reg   <= pin_a;
            prev_b_reg   <= pin_b;
            step_sum_reg <= step_sum_next;
        end
    end

endmodule

// ===== design/rebd_debounce.sv =====
// ----------------------------------------------------------------------------
// rebd_debounce
// Button debounce and periodic tick timers; emits press, release and tick.
// ----------------------------------------------------------------------------
module rebd_debounce #(
    parameter int TIMER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic                            button_level,
    input  logic [rebd_pkg::SAMPLES_W-1:0]  debounce_samples,
    input  logic [rebd_pkg::SAMPLES_W-1:0]  tick_samples,
    output rebd_pkg::button_event_t         events,
    output logic [rebd_pkg::EDGE_W-1:0]     button_edge
);
    import rebd_pkg::*;

    localparam int CMP_W = (TIMER_BITS > SAMPLES_W) ? TIMER_BITS : SAMPLES_W;

    logic                  prev_button_reg;
    logic                  prev_button_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [TIMER_BITS-1:0] deb_elapsed_reg;
    logic [TIMER_BITS-1:0] deb_elapsed_next;
    logic [TIMER_BITS-1:0] tick_elapsed_reg;
    logic [TIMER_BITS-1:0] tick_elapsed_next;
    logic [TIMER_BITS-1:0] deb_inc;
    logic [TIMER_BITS-1:0] tick_mid;

    always_comb
    begin
        deb_inc           = deb_elapsed_reg + 1'b1;
        tick_mid          = tick_elapsed_reg + 1'b1;
        prev_button_next  = prev_button_reg;
        busy_next         = busy_reg;
        deb_elapsed_next  = deb_inc;
        tick_elapsed_next = tick_mid;
        events            = '0;
        button_edge       = EDGE_NONE;
        if (button_level != prev_button_reg)
        begin
            prev_button_next = button_level;
            busy_next        = 1'b1;
            deb_elapsed_next = '0;
        end
        else
        begin
            if (busy_reg && (CMP_W'(deb_inc) >= CMP_W'(debounce_samples)))
            begin
                busy_next = 1'b0;
                tick_mid  = '0;
                if (button_level)
                begin
                    button_edge       = EDGE_RELEASE;
                    events.release_ev = 1'b1;
                end
                else
                begin
                    button_edge  = EDGE_PRESS;
                    events.press = 1'b1;
                end
            end
            if (CMP_W'(tick_mid) >= CMP_W'(tick_samples))
            begin
                tick_elapsed_next = '0;
                events.tick       = 1'b1;
            end
            else
            begin
                tick_elapsed_next = tick_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_button_reg  <= 1'b1;
            busy_reg         <= 1'b0;
            deb_elapsed_reg  <= '0;
            tick_elapsed_reg <= '0;
        end
        else if (fire)
        begin
            prev_button_reg  <= prev_button_next;
            busy_reg         <= busy_next;
            deb_elapsed_reg  <= deb_elapsed_next;
            tick_elapsed_reg <= tick_elapsed_next;
        end
    end

endmodule

// ===== design/rebd_gesture.sv =====
// ----------------------------------------------------------------------------
// rebd_gesture
// Nine-state click/hold machine; a button event then a tick may both apply
// in one sample.
// ----------------------------------------------------------------------------
module rebd_gesture (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  rebd_pkg::button_event_t          events,
    output logic [rebd_pkg::GEST_W-1:0]      gesture,
    output logic [rebd_pkg::HOLD_SEC_W-1:0]  hold_seconds
);
    import rebd_pkg::*;

    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_TICK    = 2'd2;

    typedef struct packed {
        logic [STATE_W-1:0]      state;
        logic [HOLD_TICKS_W-1:0] hold;
        logic [GEST_W-1:0]       gest;
    } gesture_ctx_t;

    function automatic logic [STATE_W-1:0] sel3(input logic [1:0] ev,
                                                input logic [STATE_W-1:0] on_press,
                                                input logic [STATE_W-1:0] on_release,
                                                input logic [STATE_W-1:0] on_tick);
        logic [STATE_W-1:0] res;
        unique case (ev)
            EV_PRESS:   res = on_press;
            EV_RELEASE: res = on_release;
            default:    res = on_tick;
        endcase
        return res;
    endfunction

    function automatic gesture_ctx_t fsm_step(input gesture_ctx_t ctx, input logic [1:0] ev);
        logic [STATE_W-1:0] cur;
        logic [STATE_W-1:0] nxt;
        logic [GEST_W-1:0]  g;
        gesture_ctx_t       res;
        cur = (ctx.state > ST_INVALID) ? ST_INVALID : ctx.state;
        g   = GEST_NONE;
        unique case (cur)
            ST_START:  nxt = sel3(ev, ST_DOWN,    ST_START,  ST_START);
            ST_DOWN:   nxt = sel3(ev, ST_DOWN,    ST_CLICK,  ST_HOLD);
            ST_CLICK:  nxt = sel3(ev, ST_DOWN2,   ST_CLICK,  ST_START);
            ST_DOWN2:  nxt = sel3(ev, ST_DOWN2,   ST_CLICK2, ST_INVALID);
            ST_CLICK2: nxt = sel3(ev, ST_DOWN3,   ST_CLICK2, ST_START);
            ST_DOWN3:  nxt = sel3(ev, ST_DOWN3,   ST_CLICK3, ST_INVALID);
            ST_CLICK3: nxt = sel3(ev, ST_INVALID, ST_CLICK3, ST_START);
            ST_HOLD:   nxt = sel3(ev, ST_HOLD,    ST_START,  ST_HOLD);
            default:   nxt = sel3(ev, ST_INVALID, ST_START,  ST_INVALID);
        endcase
        if (ev == EV_TICK)
        begin
            unique case (cur)
                ST_DOWN:   g = GEST_HOLD;
                ST_CLICK:  g = GEST_CLICK;
                ST_CLICK2: g = GEST_DOUBLE;
                ST_CLICK3: g = GEST_TRIPLE;
                ST_HOLD:   g = GEST_HOLD;
                default:   g = GEST_NONE;
            endcase
        end
        res.hold = ctx.hold;
        if (nxt == ST_HOLD)
        begin
            res.hold = ((cur != ST_HOLD) ? '0 : ctx.hold) + 1'b1;
        end
        res.state = nxt;
        // hold reported on every second tick only
        res.gest  = (g == GEST_HOLD && res.hold[0]) ? GEST_NONE : g;
        return res;
    endfunction

    logic [STATE_W-1:0]      state_reg;
    logic [HOLD_TICKS_W-1:0] hold_ticks_reg;
    gesture_ctx_t            ctx_cur;
    gesture_ctx_t            ctx_btn;
    gesture_ctx_t            ctx_next;

    always_comb
    begin
        ctx_cur = '{state: state_reg, hold: hold_ticks_reg, gest: GEST_NONE};
        if (events.press)
        begin
            ctx_btn = fsm_step(ctx_cur, EV_PRESS);
        end
        else if (events.release_ev)
        begin
            ctx_btn = fsm_step(ctx_cur, EV_RELEASE);
        end
        else
        begin
            ctx_btn = ctx_cur;
        end
        ctx_next     = events.tick ? fsm_step(ctx_btn, EV_TICK) : ctx_btn;
        gesture      = events.tick ? ctx_next.gest : GEST_NONE;
        hold_seconds = ctx_next.hold[HOLD_TICKS_W-1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_START;
            hold_ticks_reg <= '0;
        end
        else if (fire)
        begin
            state_reg      <= ctx_next.state;
            hold_ticks_reg <= ctx_next.hold;
        end
    end

endmodule

// ===== design/rotary_encoder_button_decoder.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder
// Path: each sample passes the input register, then the result register; a
// stall on the result channel can hold it in either register.
// Throughput: one sample per cycle, held only by backpressure on the result
// channel. Reset clears the decoder state and loads register defaults
// (detent 4, debounce 50, tick 500).
// ----------------------------------------------------------------------------
module rotary_encoder_button_decoder #(
    parameter int TIMER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rebd_sample_if.sink           sample_in,
    rebd_result_if.source         result_out,
    rebd_cfg_if.sink              cfg
);
    import rebd_pkg::*;

    logic [DETENT_W-1:0]  detent_steps_reg;
    logic [SAMPLES_W-1:0] debounce_samples_reg;
    logic [SAMPLES_W-1:0] tick_samples_reg;

    logic in_valid_reg;
    logic in_valid_next;
    logic pin_a_reg;
    logic pin_b_reg;
    logic button_level_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ROT_W-1:0]      rotation_reg;
    logic [EDGE_W-1:0]     button_edge_reg;
    logic [GEST_W-1:0]     gesture_reg;
    logic [HOLD_SEC_W-1:0] hold_seconds_reg;

    logic                  advance;
    logic                  fire;
    logic [ROT_W-1:0]      rotation_next;
    logic [EDGE_W-1:0]     button_edge_next;
    logic [GEST_W-1:0]     gesture_next;
    logic [HOLD_SEC_W-1:0] hold_seconds_next;
    button_event_t         events;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detent_steps_reg     <= DETENT_RESET;
            debounce_samples_reg <= DEBOUNCE_RESET;
            tick_samples_reg     <= TICK_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DETENT:   detent_steps_reg     <= cfg.data[DETENT_W-1:0];
                REG_DEBOUNCE: debounce_samples_reg <= cfg.data[SAMPLES_W-1:0];
                REG_TICK:     tick_samples_reg     <= cfg.data[SAMPLES_W-1:0];
                default:      ;
            endcase
        end
    end

    assign advance         = !out_valid_reg || result_out.ready;
    assign fire            = in_valid_reg && advance;
    assign sample_in.ready = !in_valid_reg || advance;
    assign in_valid_next   = sample_in.ready ? sample_in.valid : in_valid_reg;
    assign out_valid_next  = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            pin_a_reg        <= sample_in.pin_a;
            pin_b_reg        <= sample_in.pin_b;
            button_level_reg <= sample_in.button_level;
        end
        if (fire)
        begin
            rotation_reg     <= rotation_next;
            button_edge_reg  <= button_edge_next;
            gesture_reg      <= gesture_next;
            hold_seconds_reg <= hold_seconds_next;
        end
    end

    rebd_quad u_quad (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .pin_a        (pin_a_reg),
        .pin_b        (pin_b_reg),
        .detent_steps (detent_steps_reg),
        .rotation     (rotation_next)
    );

    rebd_debounce #(
        .TIMER_BITS (TIMER_BITS)
    ) u_debounce (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .button_level     (button_level_reg),
        .debounce_samples (debounce_samples_reg),
        .tick_samples     (tick_samples_reg),
        .events           (events),
        .button_edge      (button_edge_next)
    );

    rebd_gesture u_gesture (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .events       (events),
        .gesture      (gesture_next),
        .hold_seconds (hold_seconds_next)
    );

    assign result_out.valid        = out_valid_reg;
    assign result_out.rotation     = rotation_reg;
    assign result_out.button_edge  = button_edge_reg;
    assign result_out.gesture      = gesture_reg;
    assign result_out.hold_seconds = hold_seconds_reg;

endmodule

// ===== design/rebd_checker.sv =====
// ----------------------------------------------------------------------------
// rebd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rebd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rebd_pkg::ROT_W-1:0]    rotation,
    input logic [rebd_pkg::EDGE_W-1:0]   button_edge,
    input logic [rebd_pkg::GEST_W-1:0]   gesture
);
    import rebd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // every sample transfer must be followed by an offered result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("no result after sample transfer");

    // with no result pending the input side must be open
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result stage");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rotation != 2'd3) && (button_edge != 2'd3) &&
                      (gesture == GEST_NONE || gesture == GEST_CLICK ||
                       gesture == GEST_DOUBLE || gesture == GEST_TRIPLE ||
                       gesture == GEST_HOLD))
        else $error("undefined result code");

endmodule

bind rotary_encoder_button_decoder rebd_checker u_rebd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_in.valid),
    .in_ready    (sample_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .rotation    (result_out.rotation),
    .button_edge (result_out.button_edge),
    .gesture     (result_out.gesture)
);
